@@ hdl/crfs_pkg.sv @@
// Package for the calendar round fair scheduler: sizes, status codes and
// the operation and state types. No dependencies.
package crfs_pkg;
    localparam int NUM_BUCKETS       = 64;
    localparam int BUCKET_DEPTH      = 16;
    localparam int NUM_FLOWS         = 256;
    localparam int WEIGHT_TABLE_SIZE = 4;
    localparam int WT_W         = $clog2(WEIGHT_TABLE_SIZE);
    localparam int BKT_W        = $clog2(NUM_BUCKETS);
    localparam int SLOT_W       = $clog2(BUCKET_DEPTH);
    localparam int CNT_W        = $clog2(BUCKET_DEPTH + 1);
    localparam int BKT_ENT_W    = SLOT_W + CNT_W;
    localparam int FLOW_W       = $clog2(NUM_FLOWS);
    localparam int STORE_DEPTH  = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int TOTAL_W      = $clog2(STORE_DEPTH + 1);

    typedef enum logic [2:0] {
        t_ST_ENQ        = 3'd0,
        t_ST_DROP_BURST = 3'd1,
        t_ST_DROP_FULL  = 3'd2,
        t_ST_DEQ        = 3'd3,
        t_ST_EMPTY      = 3'd4
    } t_status;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    localparam logic [2:0] REG_BURST = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_ENQ_CHK,
        S_SCAN,
        S_DEQ_POP,
        S_DEQ,
        S_OUT
    } t_state;
endpackage

@@ hdl/crfs_ram.sv @@
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module crfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/calendar_round_fair_scheduler_core.sv @@
// Top level of the calendar round fair scheduler core.
// Depends on crfs_pkg and crfs_ram (flow round table, bucket words, bucket store).
//
// The core serves one transaction at a time; the operation travels on s_axis_tuser
// and the result status on m_axis_tuser. The flow round table, the per-bucket head
// and count words and the bucket store are synchronous memories with a registered
// read. An enqueue reads the flow's last round in its accepting cycle, computes
// the departure round in the next cycle and, in the cycle after, checks the burst
// limit and the depth of the target bucket, whose head and count word was read
// meanwhile; its result is registered at the end of that check. A dequeue tests
// one bucket per cycle in a non-empty bitmap, advancing the current round past up
// to NUM_BUCKETS-1 empty buckets, then reads the bucket word and the bucket store;
// its result is registered in S_DEQ, or straight from the scan when nothing is
// queued. The result stays in its register until it is taken, and the next
// transaction is accepted in the cycle after that. Flow rounds and bucket words
// that were never written read as zero through per-entry valid bits, so no
// clearing pass is needed after reset.
module calendar_round_fair_scheduler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // flow_id[7:0], packet_tag[23:8]
    input  logic        s_axis_tuser,  // operation[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // tag_out[15:0], round_out[47:16]
    output logic [2:0]  m_axis_tuser,  // status[2:0]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    import crfs_pkg::*;

    t_state r_state, n_state;
    logic [9:0]  r_weight [WEIGHT_TABLE_SIZE];
    logic [6:0]  r_burst;
    logic [31:0] r_cur;
    logic [TOTAL_W-1:0] r_total;
    logic [NUM_BUCKETS-1:0] r_nonempty;
    logic [NUM_BUCKETS-1:0] r_bvalid;
    logic        r_bvld_q;
    logic [NUM_FLOWS-1:0] r_fvalid;
    logic        r_op;
    logic [FLOW_W-1:0] r_fid;
    logic [15:0] r_tag;
    logic [31:0] r_dep;
    logic [2:0]  r_ost;
    logic [15:0] r_otag;
    logic [31:0] r_orand;

    logic        fl_we, st_we, bkt_we, enq_ok;
    logic [31:0] fl_rdata, dep, last_rd, ahead;
    logic [15:0] st_rdata;
    logic [STORE_AW-1:0] st_waddr, st_raddr;
    logic [BKT_W-1:0] cur_b, dep_b, wr_b, bkt_raddr, bkt_waddr;
    logic [BKT_ENT_W-1:0] bkt_rdata, bkt_wdata;
    logic [SLOT_W-1:0] bkt_head, slot;
    logic [CNT_W-1:0]  bkt_cnt;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {r_orand, r_otag};
    assign m_axis_tuser  = r_ost;

    // Flow table: read on acceptance, written when an enqueue succeeds.
    crfs_ram #(.WIDTH(32), .DEPTH(NUM_FLOWS)) u_flow (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(r_fid), .i_wdata(r_dep),
        .i_raddr(s_axis_tdata[FLOW_W-1:0]), .o_rdata(fl_rdata));

    // Bucket words: count in the upper bits, head slot in the lower bits.
    crfs_ram #(.WIDTH(BKT_ENT_W), .DEPTH(NUM_BUCKETS)) u_bkt (
        .i_clk(i_clk), .i_we(bkt_we), .i_waddr(bkt_waddr), .i_wdata(bkt_wdata),
        .i_raddr(bkt_raddr), .o_rdata(bkt_rdata));

    crfs_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(r_tag),
        .i_raddr(st_raddr), .o_rdata(st_rdata));

    // Departure round: the wrap-aware maximum of current and last round plus the flow's weight.
    always_comb begin
        logic [31:0] d;
        last_rd = r_fvalid[r_fid] ? fl_rdata : 32'd0;
        d = last_rd - r_cur;
        dep = ((d != 32'd0) && !d[31]) ? last_rd : r_cur;
        dep = dep + {22'd0, r_weight[r_fid[WT_W-1:0]]};
    end

    assign ahead     = r_dep - r_cur;
    assign cur_b     = r_cur[BKT_W-1:0];
    assign dep_b     = dep[BKT_W-1:0];
    assign wr_b      = r_dep[BKT_W-1:0];
    // The bucket word of the departure round is fetched while the round is
    // computed; otherwise the bucket of the current round is fetched.
    assign bkt_raddr = (r_state == S_ENQ) ? dep_b : cur_b;
    assign bkt_head  = r_bvld_q ? bkt_rdata[SLOT_W-1:0] : '0;
    assign bkt_cnt   = r_bvld_q ? bkt_rdata[BKT_ENT_W-1:SLOT_W] : '0;
    assign slot      = bkt_head + bkt_cnt[SLOT_W-1:0];
    assign enq_ok    = (r_state == S_ENQ_CHK) && (ahead < {25'd0, r_burst})
                       && (bkt_cnt < CNT_W'(BUCKET_DEPTH));
    assign fl_we     = enq_ok;
    assign st_we     = enq_ok;
    assign st_waddr  = {wr_b, slot};
    assign st_raddr  = {cur_b, bkt_head};
    assign bkt_we    = enq_ok || (r_state == S_DEQ_POP);
    assign bkt_waddr = enq_ok ? wr_b : cur_b;
    assign bkt_wdata = enq_ok ? {bkt_cnt + CNT_W'(1), bkt_head}
                              : {bkt_cnt - CNT_W'(1), bkt_head + SLOT_W'(1)};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_axis_tvalid) begin
                n_state = (s_axis_tuser == OP_DEQ) ? S_SCAN : S_ENQ;
            end
            S_ENQ:     n_state = S_ENQ_CHK;
            S_ENQ_CHK: n_state = S_OUT;
            S_SCAN: begin
                // A nonzero total guarantees a non-empty bucket within one turn.
                if (r_total == '0) begin
                    n_state = S_OUT;
                end else if (r_nonempty[cur_b]) begin
                    n_state = S_DEQ_POP;
                end
            end
            S_DEQ_POP: n_state = S_DEQ;
            S_DEQ:     n_state = S_OUT;
            S_OUT: if (m_axis_tready) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight   <= '{default: 10'd1};
            r_burst    <= 7'd64;
            r_cur      <= '0;
            r_total    <= '0;
            r_nonempty <= '0;
            r_bvalid   <= '0;
            r_fvalid   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index < REG_BURST) begin
                    r_weight[i_cfg_index[WT_W-1:0]] <= i_cfg_data;
                end else if (i_cfg_index == REG_BURST) begin
                    r_burst <= i_cfg_data[6:0];
                end
            end
            if (bkt_we) begin
                r_bvalid[bkt_waddr] <= 1'b1;
            end
            if (enq_ok) begin
                r_nonempty[wr_b] <= 1'b1;
                r_total          <= r_total + TOTAL_W'(1);
                r_fvalid[r_fid]  <= 1'b1;
            end
            if (r_state == S_SCAN && r_total != '0 && !r_nonempty[cur_b]) begin
                r_cur <= r_cur + 32'd1;
            end
            if (r_state == S_DEQ_POP) begin
                if (bkt_cnt == CNT_W'(1)) begin
                    r_nonempty[cur_b] <= 1'b0;
                end
                r_total <= r_total - TOTAL_W'(1);
            end
        end
    end

    // Transaction payload and result registers.
    always_ff @(posedge i_clk) begin
        r_bvld_q <= r_bvalid[bkt_raddr];
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_op  <= s_axis_tuser;
            r_fid <= s_axis_tdata[FLOW_W-1:0];
            r_tag <= s_axis_tdata[23:8];
        end
        if (r_state == S_ENQ) begin
            r_dep <= dep;
        end
        if (r_state == S_ENQ_CHK) begin
            r_otag  <= '0;
            r_orand <= r_dep;
            if (ahead >= {25'd0, r_burst}) begin
                r_ost <= t_ST_DROP_BURST;
            end else if (!enq_ok) begin
                r_ost <= t_ST_DROP_FULL;
            end else begin
                r_ost <= t_ST_ENQ;
            end
        end
        if (r_state == S_SCAN && r_total == '0) begin
            r_ost   <= t_ST_EMPTY;
            r_otag  <= '0;
            r_orand <= r_cur;
        end
        if (r_state == S_DEQ) begin
            r_ost   <= t_ST_DEQ;
            r_otag  <= st_rdata;
            r_orand <= r_cur;
        end
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input and output both open");
    a_deq_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEQ_POP) |-> (r_bvld_q && bkt_cnt != '0))
        else $error("dequeue from empty bucket");
    a_enq_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENQ) |-> (r_op == OP_ENQ)) else $error("enqueue path with dequeue op");
    a_total_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total == '0) == (r_nonempty == '0)) else $error("packet total and bitmap disagree");
endmodule

@@ test/testbench.sv @@
// Self-checking testbench for calendar_round_fair_scheduler_core.
// Depends on crfs_pkg; drives stream transactions and compares every result
// with a scoreboard built from an in-bench model of the scheduler.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import crfs_pkg::*;

    // Register indexes of the configuration port. Indexes above the burst
    // limit are unused and must be ignored by the block.
    localparam logic [2:0] REG_WEIGHT0 = 3'd0;
    localparam logic [2:0] REG_SPARE   = 3'd7;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         ITEMS_PER_PHASE = 200;
    localparam int         NUM_PHASES = 6;
    localparam int         MAX_ROWS = 32;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;  // flow_id[7:0], packet_tag[23:8]
    logic        s_axis_tuser;  // operation[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;  // tag_out[15:0], round_out[47:16]
    logic [2:0]  m_axis_tuser;  // status[2:0]
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [9:0]  i_cfg_data;

    calendar_round_fair_scheduler_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    typedef struct packed {
        t_status     status;
        logic [15:0] tag;
        logic [31:0] round;
    } sched_result_t;

    // Scheduler state mirrored by the bench.
    logic [9:0]  weight_tbl [4];
    logic [6:0]  burst_lim;
    logic [31:0] flow_round [NUM_FLOWS];
    logic [15:0] bucket_tags [NUM_BUCKETS][BUCKET_DEPTH];
    int          bkt_head [NUM_BUCKETS];
    int          bkt_count [NUM_BUCKETS];
    logic [31:0] cur_round;
    int          queued_pkts;

    sched_result_t pending_results[$];
    int            mismatch_count = 0;
    int            results_seen = 0;
    int            sender_idle_pct = 0;
    int            receiver_stall_pct = 0;
    int            idle_cycles = 0;
    int            drops_burst = 0, drops_full = 0, dequeues = 0, empties = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Departure round for an enqueue, or the served tag for a dequeue. The
    // mirrored state is updated exactly as the hardware should update it.
    function automatic sched_result_t schedule_item(t_op op, logic [7:0] flow,
                                                    logic [15:0] tag);
        sched_result_t r;
        logic [31:0]   gap;
        logic [31:0]   dep;
        int            bkt;
        r.tag = '0;
        if (op == OP_ENQ) begin
            // Wrap-aware later of the current round and the flow's round.
            gap = flow_round[flow] - cur_round;
            dep = ((gap != 0 && gap < 32'h8000_0000) ? flow_round[flow] : cur_round)
                  + 32'(weight_tbl[flow[1:0]]);
            r.round = dep;
            bkt = dep % NUM_BUCKETS;
            if (dep - cur_round >= 32'(burst_lim)) begin
                r.status = t_ST_DROP_BURST;
            end else if (bkt_count[bkt] >= BUCKET_DEPTH) begin
                r.status = t_ST_DROP_FULL;
            end else begin
                bucket_tags[bkt][(bkt_head[bkt] + bkt_count[bkt]) % BUCKET_DEPTH] = tag;
                bkt_count[bkt]++;
                flow_round[flow] = dep;
                queued_pkts++;
                r.status = t_ST_ENQ;
            end
        end else begin
            if (queued_pkts != 0) begin
                // Skip empty buckets, at most one full turn of the calendar.
                for (int n = 0; n < NUM_BUCKETS; n++) begin
                    if (bkt_count[cur_round % NUM_BUCKETS] != 0) break;
                    cur_round++;
                end
            end
            bkt = cur_round % NUM_BUCKETS;
            r.round = cur_round;
            if (queued_pkts == 0 || bkt_count[bkt] == 0) begin
                r.status = t_ST_EMPTY;
            end else begin
                r.tag = bucket_tags[bkt][bkt_head[bkt]];
                bkt_head[bkt] = (bkt_head[bkt] + 1) % BUCKET_DEPTH;
                bkt_count[bkt]--;
                queued_pkts--;
                r.status = t_ST_DEQ;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR at %0t: result %0d %s got 0x%0h, expected 0x%0h",
                 $realtime, results_seen, what, got, want);
        mismatch_count++;
    endtask

    // Result checker: each output transaction is matched with the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        sched_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction, status", 32'(m_axis_tuser), 0);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (m_axis_tuser != want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[15:0] != want.tag)
                    report_mismatch("tag_out", 32'(m_axis_tdata[15:0]), 32'(want.tag));
                if (m_axis_tdata[47:16] != want.round)
                    report_mismatch("round_out", m_axis_tdata[47:16], want.round);
            end
        end
    end

    // Receiver back-pressure, random per cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: a long stretch without any accepted transaction means a hang.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Sends one input transaction and queues its expected result once the
    // handshake has happened. Optional idle cycles come first.
    task automatic send_item(t_op op, logic [7:0] flow, logic [15:0] tag,
                             output sched_result_t predicted);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tag, flow};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = schedule_item(op, flow, tag);
        pending_results.insert(pending_results.size(), predicted);
        unique case (predicted.status)
            t_ST_DROP_BURST: drops_burst++;
            t_ST_DROP_FULL:  drops_full++;
            t_ST_DEQ:        dequeues++;
            t_ST_EMPTY:      empties++;
            default: ;
        endcase
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes all registers plus an unused index, which must change nothing.
    task automatic write_settings(logic [9:0] w0, logic [9:0] w1, logic [9:0] w2,
                                  logic [9:0] w3, logic [9:0] burst);
        logic [9:0] vals [5];
        vals = '{w0, w1, w2, w3, burst};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_WEIGHT0 + 3'(i);
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
        end
        for (int i = 0; i < 4; i++) weight_tbl[i] = vals[i];
        burst_lim = vals[4][6:0];
        i_cfg_index <= REG_SPARE;
        i_cfg_data  <= $urandom_range(1023);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Directed rows: check set means the expected result is given here as
    // well; other rows rely on the model alone.
    typedef struct {
        t_op           op;
        logic [7:0]    flow;
        logic [15:0]   tag;
        bit            check;
        sched_result_t want;
    } directed_row_t;

    directed_row_t directed_rows [MAX_ROWS];
    int            num_rows = 0;

    function automatic void add_row(t_op op, logic [7:0] flow, logic [15:0] tag,
                                    bit check, sched_result_t want);
        directed_row_t row_new;
        row_new.op    = op;
        row_new.flow  = flow;
        row_new.tag   = tag;
        row_new.check = check;
        row_new.want  = want;
        directed_rows[num_rows] = row_new;
        num_rows++;
    endfunction

    // Per phase: four weights, burst limit, sender idle percent, receiver
    // stall percent, enqueue percent.
    int phase_cfg [NUM_PHASES][8] = '{
        '{1,    1, 1, 1,    64,  0,  0,  60},
        '{1023, 1, 2, 3,    64,  50, 0,  55},
        '{0,    1, 0, 2,    16,  0,  50, 70},
        '{5,    9, 3, 1,    1,   38, 38, 50},
        '{0,    0, 0, 0,    0,   50, 0,  50},
        '{2,    1, 1, 3,    1023, 38, 38, 85}
    };

    initial begin
        sched_result_t got;
        t_op           op;
        logic [7:0]    flow;
        directed_row_t row;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        m_axis_tready <= 1'b0;

        for (int i = 0; i < 4; i++) weight_tbl[i] = 10'd1;
        burst_lim = 7'd64;
        for (int i = 0; i < NUM_FLOWS; i++) flow_round[i] = '0;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            bkt_head[i] = 0;
            bkt_count[i] = 0;
        end
        cur_round = '0;
        queued_pkts = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: every weight is one, so the first rounds are easy to
        // read off. Empty at start, two packets sharing a round, a flow
        // chaining onto its own last round, then draining to empty again.
        add_row(OP_DEQ, 8'd0,   16'h0000, 1, '{t_ST_EMPTY, 16'h0, 32'd0});
        add_row(OP_ENQ, 8'd0,   16'hFFFF, 1, '{t_ST_ENQ, 16'h0, 32'd1});
        add_row(OP_ENQ, 8'd255, 16'h0000, 1, '{t_ST_ENQ, 16'h0, 32'd1});
        add_row(OP_ENQ, 8'd0,   16'h1234, 1, '{t_ST_ENQ, 16'h0, 32'd2});
        add_row(OP_DEQ, 8'd0,   16'h0000, 1, '{t_ST_DEQ, 16'hFFFF, 32'd1});
        add_row(OP_DEQ, 8'd7,   16'hABCD, 1, '{t_ST_DEQ, 16'h0000, 32'd1});
        add_row(OP_DEQ, 8'd0,   16'h0000, 1, '{t_ST_DEQ, 16'h1234, 32'd2});
        add_row(OP_DEQ, 8'd0,   16'h0000, 1, '{t_ST_EMPTY, 16'h0, 32'd2});
        // Sixteen fresh flows fill the bucket of round three; the seventeenth
        // finds it full and is dropped without recording its round.
        for (int i = 0; i < 16; i++)
            add_row(OP_ENQ, 8'(10 + i), 16'(16'h5A00 + i), 0, '0);
        add_row(OP_ENQ, 8'd26, 16'h7777, 1, '{t_ST_DROP_FULL, 16'h0, 32'd3});

        for (int i = 0; i < num_rows; i++) begin
            row = directed_rows[i];
            send_item(row.op, row.flow, row.tag, got);
            if (row.check && got != row.want)
                report_mismatch("directed row model", 32'(i), 0);
        end
        drain();

        // Random phases, each with its own register settings and idling.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_settings(10'(phase_cfg[p][0]), 10'(phase_cfg[p][1]), 10'(phase_cfg[p][2]),
                           10'(phase_cfg[p][3]), 10'(phase_cfg[p][4]));
            sender_idle_pct    = phase_cfg[p][5];
            receiver_stall_pct = phase_cfg[p][6];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                op = ($urandom_range(99) < phase_cfg[p][7]) ? OP_ENQ : OP_DEQ;
                // A few busy flows give chained rounds and full buckets; the
                // rest spread over the whole flow range.
                flow = ($urandom_range(3) != 0) ? 8'($urandom_range(7))
                                                : 8'($urandom_range(255));
                send_item(op, flow, 16'($urandom_range(65535)), got);
                // In phase two only, part way through, stop sending until everything is back.
                if (n == ITEMS_PER_PHASE / 2 && p == 2) drain();
            end
            drain();
        end

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (80) @(posedge i_clk);

        $display("Covered %0d results over %0d register settings: %0d served, %0d empty,",
                 results_seen, NUM_PHASES + 1, dequeues, empties);
        $display("%0d burst drops and %0d full-bucket drops.", drops_burst, drops_full);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hdl/crfs_pkg.sv
hdl/crfs_ram.sv
hdl/calendar_round_fair_scheduler_core.sv
test/testbench.sv
